/* sv/zpd_pkg.sv */
// Shared types and constants for the ZP-coder decoder.
package zpd_pkg;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_PUSH  = 3'd1,
    OP_START = 3'd2,
    OP_CTX   = 3'd3,
    OP_PASS  = 3'd4,
    OP_IW    = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TREAD,
    ST_SPLIT,
    ST_DECIDE,
    ST_RENORM,
    ST_FILL,
    ST_POP0,
    ST_POP1,
    ST_FENCE,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic split;
    logic decide;
    logic renorm;
    logic fill;
    logic start_init;
    logic pop0;
    logic pop1;
    logic fence;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fast_path;
    logic need_fill;
    logic fill_more;
  } sts_t;

  localparam logic [4:0] DelayReset = 5'd25;

endpackage

/* sv/zpd_ram.sv */
// Generic single-port-write, registered-read RAM.
module zpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* sv/zpd_ctrl.sv */
// Controller state machine sequencing each decoder operation.
module zpd_ctrl import zpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [2:0] op_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          case (op_e'(op_i))
            OP_START: state_d = ST_POP0;
            OP_CTX:   state_d = ST_TREAD;
            OP_PASS,
            OP_IW:    state_d = ST_SPLIT;
            default:  state_d = ST_OUT;
          endcase
        end
      end
      ST_TREAD: state_d = ST_SPLIT;
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = sts_i.fast_path ? ST_OUT : ST_RENORM;
      end
      ST_RENORM: begin
        cmd_o.renorm = 1'b1;
        state_d = sts_i.need_fill ? ST_FILL : ST_FENCE;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (!sts_i.fill_more) state_d = ST_FENCE;
      end
      ST_POP0: begin
        cmd_o.start_init = 1'b1;
        cmd_o.pop0 = 1'b1;
        state_d = ST_POP1;
      end
      ST_POP1: begin
        cmd_o.pop1 = 1'b1;
        state_d = ST_FILL;
      end
      ST_FENCE: begin
        cmd_o.fence = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* sv/zpd_dp.sv */
// Datapath: coder registers, state tables, byte FIFO and renormalization.
module zpd_dp import zpd_pkg::*; #(
  parameter int FifoDepth = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [2:0] op_i,
  input  logic [7:0] byte_in_i,
  input  logic [7:0] table_index_i,
  input  logic [15:0] prob_value_i,
  input  logic [15:0] mps_threshold_i,
  input  logic [7:0] up_state_i,
  input  logic [7:0] down_state_i,
  input  logic [7:0] ctx_state_i,
  output logic       bit_out_o,
  output logic [7:0] new_ctx_state_o,
  output logic       end_of_data_o,
  output logic       fifo_overflow_o
);
  localparam int AW = $clog2(FifoDepth);
  localparam int LW = $clog2(FifoDepth + 1);
  localparam logic [LW-1:0] FullLvl = LW'(FifoDepth);
  localparam logic [AW-1:0] LastIdx = AW'(FifoDepth - 1);

  logic [15:0] interval_q, code_q, fence_q, z_q, t_q;
  logic [17:0] a_q;
  logic [31:0] buf_q;
  logic [5:0]  cnt_q;
  logic [4:0]  delay_q;
  logic        end_q, bit_q, ovf_q, lps_q;
  logic [7:0]  ctx_q;
  logic [2:0]  op_q;
  logic [LW-1:0] lvl_q;
  logic [AW-1:0] rd_q;

  logic [15:0] prob_rd, thr_rd;
  logic [7:0]  up_rd, dn_rd, fifo_rd;
  logic        is_load, is_push, push_ok;
  logic [AW-1:0] wr_idx, rd_next, fifo_raddr;
  logic [LW:0]   wsum;
  logic        empty, pop_now;
  logic [7:0]  popb;

  assign is_load = cmd_i.latch_in && (op_e'(op_i) == OP_LOAD);
  assign is_push = cmd_i.latch_in && (op_e'(op_i) == OP_PUSH);
  assign push_ok = is_push && (lvl_q < FullLvl);
  assign wsum    = {1'b0, {(LW-AW){1'b0}}, rd_q} + {1'b0, lvl_q};
  assign wr_idx  = (wsum >= (LW+1)'(FifoDepth)) ? AW'(wsum - (LW+1)'(FifoDepth)) : AW'(wsum);
  assign rd_next = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
  assign empty   = (lvl_q == '0);
  assign popb    = empty ? 8'hff : fifo_rd;
  assign pop_now = (cmd_i.fill || cmd_i.pop0 || cmd_i.pop1) && !empty;
  // While a byte is popped the next head is read, so the registered word tracks the head.
  assign fifo_raddr = pop_now ? rd_next : rd_q;

  zpd_ram #(.Width(16), .Depth(256)) u_prob (.clk_i, .we_i(is_load), .waddr_i(table_index_i),
    .wdata_i(prob_value_i), .raddr_i(ctx_q), .rdata_o(prob_rd));
  zpd_ram #(.Width(16), .Depth(256)) u_thr (.clk_i, .we_i(is_load), .waddr_i(table_index_i),
    .wdata_i(mps_threshold_i), .raddr_i(ctx_q), .rdata_o(thr_rd));
  zpd_ram #(.Width(8), .Depth(256)) u_up (.clk_i, .we_i(is_load), .waddr_i(table_index_i),
    .wdata_i(up_state_i), .raddr_i(ctx_q), .rdata_o(up_rd));
  zpd_ram #(.Width(8), .Depth(256)) u_dn (.clk_i, .we_i(is_load), .waddr_i(table_index_i),
    .wdata_i(down_state_i), .raddr_i(ctx_q), .rdata_o(dn_rd));
  zpd_ram #(.Width(8), .Depth(FifoDepth)) u_fifo (.clk_i, .we_i(push_ok), .waddr_i(wr_idx),
    .wdata_i(byte_in_i), .raddr_i(fifo_raddr), .rdata_o(fifo_rd));

  // Split computation.
  logic [16:0] zc, dlim, zsel;
  logic [17:0] sum2;
  always_comb begin
    sum2 = 18'd0;
    dlim = 17'd0;
    case (op_e'(op_q))
      OP_CTX: begin
        zc   = {1'b0, interval_q} + {1'b0, prob_rd};
        sum2 = {1'b0, zc} + {2'b0, interval_q};
        dlim = 17'h6000 + {1'b0, sum2[17:2]};
      end
      OP_PASS: zc = 17'h8000 + {2'b0, interval_q[15:1]};
      default: zc = 17'h8000 + 17'((18'(interval_q) * 18'd3) >> 3);
    endcase
    zsel = zc;
  end

  // The clamped split can exceed 16 bits, and the LPS interval can also pass 16 bits,
  // so it is kept 18 bits wide for the leading-ones range check.
  logic [16:0] zz;
  logic [17:0] a_full;
  assign zz     = ((op_e'(op_q) == OP_CTX) && (zc > dlim)) ? dlim : zc;
  assign a_full = {2'b0, interval_q} + 18'h10000 - {1'b0, zz};

  // Leading ones of the LPS interval.
  logic [4:0] sh;
  logic [7:0] lob;
  logic [3:0] lo8;
  always_comb begin
    lob = (a_q < 18'h0ff00) ? a_q[15:8] : a_q[7:0];
    lo8 = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (!lob[i]) lo8 = 4'(7 - i);
    end
    sh = (a_q < 18'h0ff00) ? {1'b0, lo8} : {1'b0, lo8} + 5'd8;
  end

  logic [5:0]  cnt_new;
  logic [31:0] bits;
  logic [15:0] mask;
  always_comb begin
    cnt_new = lps_q ? ((cnt_q >= 6'(sh)) ? cnt_q - 6'(sh) : 6'd0)
                    : ((cnt_q != 0) ? cnt_q - 6'd1 : 6'd0);
    bits = cnt_new[5] ? 32'd0 : (buf_q >> cnt_new[4:0]);
    mask = lps_q ? 16'((17'd1 << sh) - 17'd1) : 16'd1;
  end

  assign sts_o.fast_path = (op_e'(op_q) == OP_CTX) && (zc <= {1'b0, fence_q});
  assign sts_o.need_fill = cnt_new < 6'd16;
  assign sts_o.fill_more = (cnt_q + 6'd8) <= 6'd24;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0; code_q <= '0; fence_q <= '0; buf_q <= '0; cnt_q <= '0;
      delay_q <= DelayReset; end_q <= 1'b0; lvl_q <= '0; rd_q <= '0;
    end else begin
      if (push_ok) lvl_q <= lvl_q + 1'b1;
      if (cmd_i.decide && sts_o.fast_path) interval_q <= zc[15:0];
      if (cmd_i.renorm) begin
        cnt_q <= cnt_new;
        if (lps_q) begin
          interval_q <= a_q[15:0] << sh;
          code_q <= (t_q << sh) | (bits[15:0] & mask);
        end else begin
          interval_q <= {z_q[14:0], 1'b0};
          code_q <= {code_q[14:0], bits[0]};
        end
      end
      if (cmd_i.fill) begin
        buf_q <= {buf_q[23:0], popb};
        cnt_q <= cnt_q + 6'd8;
        if (empty) begin
          if (delay_q > 1) delay_q <= delay_q - 1'b1;
          else begin
            delay_q <= '0;
            end_q <= 1'b1;
          end
        end
      end
      if (cmd_i.start_init) begin
        interval_q <= '0; buf_q <= '0; cnt_q <= '0; end_q <= 1'b0;
        delay_q <= DelayReset;
      end
      if (cmd_i.pop0) code_q[15:8] <= popb;
      if (cmd_i.pop1) code_q[7:0] <= popb;
      if (pop_now) begin
        rd_q  <= rd_next;
        lvl_q <= lvl_q - 1'b1;
      end
      if (cmd_i.fence) fence_q <= code_q[15] ? 16'h7fff : code_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= op_i;
      ctx_q <= ctx_state_i;
      bit_q <= 1'b0;
      ovf_q <= is_push && !push_ok;
    end
    if (cmd_i.split) z_q <= zsel[15:0];
    if (cmd_i.decide) begin
      if (sts_o.fast_path) bit_q <= ctx_q[0];
      else begin
        z_q   <= zz[15:0];
        lps_q <= zz > {1'b0, code_q};
        t_q   <= code_q - zz[15:0];
        a_q   <= a_full;
        if (zz > {1'b0, code_q}) begin
          bit_q <= (op_e'(op_q) == OP_CTX) ? !ctx_q[0] : 1'b1;
          if (op_e'(op_q) == OP_CTX) ctx_q <= dn_rd;
        end else begin
          bit_q <= (op_e'(op_q) == OP_CTX) ? ctx_q[0] : 1'b0;
          if (op_e'(op_q) == OP_CTX && interval_q >= thr_rd) ctx_q <= up_rd;
        end
      end
    end
  end

  assign bit_out_o       = bit_q;
  assign new_ctx_state_o = ctx_q;
  assign end_of_data_o   = end_q;
  assign fifo_overflow_o = ovf_q;
endmodule

/* sv/adaptive_binary_arith_decoder.sv */
// Top level of the adaptive binary arithmetic (ZP-coder) decoder.
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_ready_o | op_i .. ctx_state_i
//  out     | output    | out_valid_o/out_ready_i | bit_out_o .. fifo_overflow_o
// Table loads, pushes and unused ops go straight to the result; decodes run the table read
// (context decodes only), the split, the decision, then on the slow path the renormalization and
// up to four FIFO byte refills at one per cycle; start pops two code bytes and then refills.
// Reset clears the coder registers and the FIFO count; tables are undefined.
// One transaction is in flight at a time; the result holds until taken.
module adaptive_binary_arith_decoder import zpd_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  byte_in_i,
  input  logic [7:0]  table_index_i,
  input  logic [15:0] prob_value_i,
  input  logic [15:0] mps_threshold_i,
  input  logic [7:0]  up_state_i,
  input  logic [7:0]  down_state_i,
  input  logic [7:0]  ctx_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        bit_out_o,
  output logic [7:0]  new_ctx_state_o,
  output logic        end_of_data_o,
  output logic        fifo_overflow_o
);
  cmd_t cmd;
  sts_t sts;

  zpd_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .out_valid_o,
    .out_ready_i, .sts_i(sts), .cmd_o(cmd));

  zpd_dp #(.FifoDepth(FIFO_DEPTH)) u_dp (.clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .op_i,
    .byte_in_i, .table_index_i, .prob_value_i, .mps_threshold_i, .up_state_i,
    .down_state_i, .ctx_state_i, .bit_out_o, .new_ctx_state_o, .end_of_data_o,
    .fifo_overflow_o);
endmodule

/* verif/tb_adaptive_binary_arith_decoder.sv */
// Self-checking testbench for the adaptive binary arithmetic (ZP-coder) decoder.
module tb_adaptive_binary_arith_decoder;
  import zpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FifoDepth  = 16;
  localparam int          NumRandom  = 1750;
  localparam int          CycleLimit = 400000;
  localparam int          LongHold   = 250;
  localparam logic [2:0]  OpSpareLo  = 3'd6;
  localparam logic [2:0]  OpSpareHi  = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  byte_in;
    logic [7:0]  table_index;
    logic [15:0] prob_value;
    logic [15:0] mps_threshold;
    logic [7:0]  up_state;
    logic [7:0]  down_state;
    logic [7:0]  ctx_state;
  } zp_item_t;

  typedef struct {
    logic       bit_out;
    logic [7:0] new_ctx;
    logic       eod;
    logic       ovf;
  } zp_result_t;

  // Mirror of the coder state; predicts one result per transaction.
  class zp_scoreboard;
    int unsigned ivl, code, fence, bitbuf, nbits, delay, lvl, rd;
    bit          eod;
    bit [15:0]   prob[256];
    bit [15:0]   thr[256];
    bit [7:0]    up[256];
    bit [7:0]    dn[256];
    bit [7:0]    fifo[FifoDepth];
    zp_result_t  expected_q[$];
    int          errors;

    function new();
      ivl = 0; code = 0; fence = 0; bitbuf = 0; nbits = 0;
      delay = DelayReset; eod = 0; lvl = 0; rd = 0; errors = 0;
    endfunction

    function bit pop_byte(output int unsigned b);
      if (lvl == 0) begin
        b = 32'hff;
        return 0;
      end
      b = fifo[rd];
      rd = (rd + 1 >= FifoDepth) ? 0 : rd + 1;
      lvl--;
      return 1;
    endfunction

    function void refill();
      int unsigned b;
      while (nbits <= 24) begin
        if (!pop_byte(b)) begin
          if (delay > 0) delay--;
          if (delay == 0) eod = 1;
        end
        bitbuf = (bitbuf << 8) | (b & 32'hff);
        nbits += 8;
      end
    endfunction

    function int unsigned ones8(int unsigned v);
      int unsigned n;
      n = 0;
      while (n < 8 && (v & (32'h80 >> n)) != 0) n++;
      return n;
    endfunction

    function int unsigned lead_ones(int unsigned x);
      return (x < 32'hff00) ? ones8((x >> 8) & 32'hff) : ones8(x & 32'hff) + 8;
    endfunction

    function int unsigned buf_bits(int unsigned s);
      return (s >= 32) ? 0 : (bitbuf >> s);
    endfunction

    function void finish_renorm();
      if (nbits < 16) refill();
      fence = (code >= 32'h8000) ? 32'h7fff : code;
    endfunction

    function void shift_lps(int unsigned z);
      int unsigned t, a, c, sh;
      t = 32'h10000 - z;
      a = ivl + t;
      c = code + t;
      sh = lead_ones(a);
      nbits = (nbits >= sh) ? nbits - sh : 0;
      ivl = (a << sh) & 32'hffff;
      code = ((c << sh) & 32'hffff) | (buf_bits(nbits) & ((32'd1 << sh) - 1));
      finish_renorm();
    endfunction

    function void shift_mps(int unsigned z);
      nbits = (nbits >= 1) ? nbits - 1 : 0;
      ivl = (z << 1) & 32'hffff;
      code = ((code << 1) & 32'hffff) | (buf_bits(nbits) & 1);
      finish_renorm();
    endfunction

    function bit split_decode(int unsigned z);
      if (z > code) begin
        shift_lps(z);
        return 1;
      end
      shift_mps(z);
      return 0;
    endfunction

    function bit ctx_decode(inout logic [7:0] ctx);
      int unsigned c, z, d;
      bit          mps;
      c = ctx;
      mps = ctx[0];
      z = ivl + prob[c];
      if (z <= fence) begin
        ivl = z & 32'hffff;
        return mps;
      end
      d = 32'h6000 + ((z + ivl) >> 2);
      if (z > d) z = d;
      if (z > code) begin
        ctx = dn[c];
        shift_lps(z);
        return !mps;
      end
      if (ivl >= thr[c]) ctx = up[c];
      shift_mps(z);
      return mps;
    endfunction

    function void init_coder();
      int unsigned b0, b1;
      ivl = 0; bitbuf = 0; nbits = 0; eod = 0;
      void'(pop_byte(b0));
      void'(pop_byte(b1));
      code = ((b0 & 32'hff) << 8) | (b1 & 32'hff);
      delay = DelayReset;
      refill();
      fence = (code >= 32'h8000) ? 32'h7fff : code;
    endfunction

    function void note_input(zp_item_t it);
      zp_result_t r;
      logic [7:0] ctx;
      ctx = it.ctx_state;
      r.bit_out = 0;
      r.ovf = 0;
      case (it.op)
        OP_LOAD: begin
          prob[it.table_index] = it.prob_value;
          thr[it.table_index] = it.mps_threshold;
          up[it.table_index] = it.up_state;
          dn[it.table_index] = it.down_state;
        end
        OP_PUSH: begin
          if (lvl >= FifoDepth) begin
            r.ovf = 1;
          end else begin
            fifo[(rd + lvl) % FifoDepth] = it.byte_in;
            lvl++;
          end
        end
        OP_START: init_coder();
        OP_CTX:   r.bit_out = ctx_decode(ctx);
        OP_PASS:  r.bit_out = split_decode(32'h8000 + (ivl >> 1));
        OP_IW:    r.bit_out = split_decode(32'h8000 + ((3 * ivl) >> 3));
        default: ;
      endcase
      r.new_ctx = ctx;
      r.eod = eod;
      expected_q.push_back(r);
    endfunction

    function void check_result(zp_result_t act);
      zp_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (act.bit_out !== exp_r.bit_out) begin
        $error("bit_out: expected %0d, got %0d", exp_r.bit_out, act.bit_out);
        errors++;
      end
      if (act.new_ctx !== exp_r.new_ctx) begin
        $error("new_ctx_state: expected %0d, got %0d", exp_r.new_ctx, act.new_ctx);
        errors++;
      end
      if (act.eod !== exp_r.eod) begin
        $error("end_of_data: expected %0d, got %0d", exp_r.eod, act.eod);
        errors++;
      end
      if (act.ovf !== exp_r.ovf) begin
        $error("fifo_overflow: expected %0d, got %0d", exp_r.ovf, act.ovf);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i = '0;
  logic [7:0]  byte_in_i = '0;
  logic [7:0]  table_index_i = '0;
  logic [15:0] prob_value_i = '0;
  logic [15:0] mps_threshold_i = '0;
  logic [7:0]  up_state_i = '0;
  logic [7:0]  down_state_i = '0;
  logic [7:0]  ctx_state_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        bit_out_o;
  logic [7:0]  new_ctx_state_o;
  logic        end_of_data_o;
  logic        fifo_overflow_o;

  zp_scoreboard sb = new();
  bit           loaded[256];
  bit           hold_req = 0;
  int           burst_left = 0;

  adaptive_binary_arith_decoder u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    zp_result_t act;
    if (out_valid_o && out_ready_i) begin
      act.bit_out = bit_out_o;
      act.new_ctx = new_ctx_state_o;
      act.eod = end_of_data_o;
      act.ovf = fifo_overflow_o;
      sb.check_result(act);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold-off on request.
  initial begin
    int mode, span;
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = $urandom_range(0, 1);
          2:       out_ready_i = ($urandom_range(0, 4) == 0);
          default: out_ready_i = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic zp_item_t random_fields(logic [2:0] op);
    zp_item_t it;
    it.op = op;
    it.byte_in = $urandom;
    it.table_index = $urandom;
    it.prob_value = $urandom;
    it.mps_threshold = $urandom;
    it.up_state = $urandom;
    it.down_state = $urandom;
    it.ctx_state = $urandom;
    return it;
  endfunction

  function automatic logic [7:0] pick_loaded();
    logic [7:0] c;
    c = $urandom;
    while (!loaded[c]) c++;
    return c;
  endfunction

  function automatic zp_item_t next_random_item(bit any_loaded);
    zp_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it = random_fields(OP_LOAD);
      if ($urandom_range(0, 7) == 0) it.prob_value = $urandom_range(0, 1) ? 16'hffff : 16'h0;
      loaded[it.table_index] = 1;
    end else if (r < 32) begin
      it = random_fields(OP_PUSH);
    end else if (r < 35) begin
      it = random_fields(OP_START);
    end else if (r < 70 && any_loaded) begin
      it = random_fields(OP_CTX);
      it.ctx_state = pick_loaded();
    end else if (r < 84) begin
      it = random_fields(OP_PASS);
    end else if (r < 98) begin
      it = random_fields(OP_IW);
    end else begin
      it = random_fields(r[0] ? OpSpareLo : OpSpareHi);
    end
    return it;
  endfunction

  // Presents one transaction; called and returns at a falling edge.
  task automatic send_item(zp_item_t it);
    in_valid_i = 1'b1;
    op_i = it.op;
    byte_in_i = it.byte_in;
    table_index_i = it.table_index;
    prob_value_i = it.prob_value;
    mps_threshold_i = it.mps_threshold;
    up_state_i = it.up_state;
    down_state_i = it.down_state;
    ctx_state_i = it.ctx_state;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
      @(negedge clk_i);
    end
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(bit allow);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      if (allow) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    zp_item_t it;
    bit       any_loaded;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Decodes on the reset state, before any start, and the unused opcodes.
    send_item(random_fields(OP_PASS));
    send_item(random_fields(OP_IW));
    send_item(random_fields(OpSpareLo));
    send_item(random_fields(OpSpareHi));
    it = random_fields(OP_LOAD);
    it.table_index = 8'h00; it.prob_value = '0; it.mps_threshold = '0;
    it.up_state = 8'h00; it.down_state = 8'h00;
    send_item(it);
    it = random_fields(OP_LOAD);
    it.table_index = 8'hff; it.prob_value = '1; it.mps_threshold = '1;
    it.up_state = 8'hff; it.down_state = 8'hff;
    send_item(it);
    it = random_fields(OP_LOAD);
    it.table_index = 8'h01; it.prob_value = 16'h4000;
    send_item(it);
    loaded[8'h00] = 1; loaded[8'h01] = 1; loaded[8'hff] = 1;
    for (int i = 0; i < 4; i++) begin
      it = random_fields(OP_PUSH);
      it.byte_in = (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom);
      send_item(it);
    end
    send_item(random_fields(OP_START));
    it = random_fields(OP_CTX); it.ctx_state = 8'h00; send_item(it);
    it = random_fields(OP_CTX); it.ctx_state = 8'h01; send_item(it);
    it = random_fields(OP_CTX); it.ctx_state = 8'hff; send_item(it);
    send_item(random_fields(OP_PASS));
    send_item(random_fields(OP_IW));
    it = random_fields(OP_CTX); it.ctx_state = 8'h01; send_item(it);

    any_loaded = 1;
    for (int n = 0; n < NumRandom; n++) begin
      // The long hold-off lands while the sender keeps offering transactions.
      if (n == NumRandom / 4) hold_req = 1;
      if (n == NumRandom / 2) wait_drained();
      send_item(next_random_item(any_loaded));
      sender_gap(n > NumRandom / 4 + 300 || n < NumRandom / 4);
    end
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
